// ===== design/chte_pkg.sv =====
// Package for the chained hash table engine: opcodes, status codes,
// sequencer states and sizing constants. No dependencies.
`default_nettype none
package chte_pkg;
  localparam int MaxBucketsDef     = 64;
  localparam int SlotsPerBucketDef = 8;
  localparam int NumBucketsRst     = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_CLEAR,
    S_RESP
  } state_t;
endpackage
`default_nettype wire

// ===== design/chte_if.sv =====
// Valid/ready channel interface for the input and result channels of the
// hash table engine. Depends on nothing; the payload type is a parameter.
`default_nettype none
interface chte_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/chained_hash_table_engine.sv =====
// Top level of the chained hash table engine: sequencer, fill counts and
// configuration. Depends on chte_pkg, chte_if, chte_mod and chte_store.
//
// Key/value store with separate chaining. A transfer on the input channel
// carries an opcode (insert, get, remove, clear), a key and a value; each
// item answers with exactly one result transfer carrying a status and a
// found value. The bucket is the sign-extended key modulo the configured
// bucket count (0 reads as 1, counts above MAX_BUCKETS saturate), worked
// out by a bit-serial restoring divider, which dominates the latency. A
// get or remove then scans the bucket slot by slot, with a read state and
// a compare state per slot, through the registered read port of the slot
// memory, and a remove shifts younger entries down with a read state and
// a write state per slot. A clear takes no divider pass. One item is
// handled at a time and in_ready is low until the result has been
// presented, so the next item can be taken in the following cycle. A
// result waiting in the output register does not stop the block taking
// the next item; only when that next result is ready while the previous
// one is still waiting does the sequencer hold in its final state. Fill
// counts live in a small memory with one valid bit per bucket, so clear
// and reset simply drop the valid bits. Slot memories need no clearing
// after reset.
`default_nettype none
module chained_hash_table_engine
  import chte_pkg::*;
#(
  parameter int MAX_BUCKETS      = MaxBucketsDef,
  parameter int SLOTS_PER_BUCKET = SlotsPerBucketDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_num_buckets
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DW = $clog2(MAX_BUCKETS + 1);
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int AW = BW + SW;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
  } in_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
  } out_t;

  chte_if #(.payload_t(in_t))  in_ch ();
  chte_if #(.payload_t(out_t)) out_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.data  = '{opcode: in_opcode, key: in_key, value: in_value};
  assign in_ready    = in_ch.ready;
  assign out_valid       = out_ch.valid;
  assign out_ch.ready    = out_ready;
  assign out_status      = out_ch.data.status;
  assign out_found_value = out_ch.data.found_value;

  // Configuration register, kept as the raw 7-bit write.
  logic [6:0] nb_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= 7'(NumBucketsRst);
    end else if (cfg_valid) begin
      nb_r <= cfg_num_buckets;
    end
  end

  // Effective divisor: zero reads as one, large values saturate.
  logic [DW-1:0] divisor;
  always_comb begin
    if (nb_r == 7'd0) begin
      divisor = DW'(1);
    end else if (32'(nb_r) > MAX_BUCKETS) begin
      divisor = DW'(MAX_BUCKETS);
    end else begin
      divisor = DW'(nb_r);
    end
  end

  state_t           state_r, state_nxt;
  logic [1:0]       op_r;
  logic [31:0]      key_r, val_r;
  logic [BW-1:0]    bkt_r;
  logic [FW-1:0]    fill_cur;
  logic [FW-1:0]    idx_r, idx_nxt;
  logic             ov_r;
  out_t             wres_r;
  out_t             res_r;
  logic             resp_go;

  // Fill counts: a small memory read once per non-clear item, plus one valid bit per
  // bucket that says whether its count has been written since the last
  // clear.
  logic [FW-1:0]          fill_mem [MAX_BUCKETS];
  logic [FW-1:0]          fill_rd_r;
  logic [MAX_BUCKETS-1:0] bkt_vld_r;
  logic                   bkt_live_r;
  logic                   fill_we;
  logic [FW-1:0]          fill_wdata;

  logic          mod_start;
  logic          mod_done;
  logic [DW-1:0] rem;
  logic [BW-1:0] rem_b;

  // The divider is loaded at the accepting edge, so it takes the key
  // straight from the input channel.
  chte_mod #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend ({{32{in_ch.data.key[31]}}, in_ch.data.key}),
    .divisor  (divisor),
    .done     (mod_done),
    .remainder(rem)
  );
  assign rem_b = BW'(rem);

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wkey, wval, rkey, rval;
  logic [SW-1:0] idx_s;
  assign idx_s = idx_r[SW-1:0];

  chte_store #(.AW(AW)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wkey (wkey),
    .wval (wval),
    .raddr(raddr),
    .rkey (rkey),
    .rval (rval)
  );

  assign fill_cur = bkt_live_r ? fill_rd_r : '0;
  assign in_ch.ready = (state_r == S_IDLE);
  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  // The finished result moves to the output register once that is free.
  assign resp_go = (state_r == S_RESP) && (!ov_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.data.opcode == OP_CLEAR) ? S_CLEAR : S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (op_r == OP_INSERT) begin
          state_nxt = S_INSERT;
        end else if (fill_cur == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (rkey == key_r) begin
          state_nxt = (op_r == OP_REMOVE) ? S_SHIFT_RD : S_RESP;
        end else if (idx_r + FW'(1) >= fill_cur) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = (idx_r + FW'(1) >= fill_cur) ? S_RESP : S_SHIFT_WR;
      end
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_INSERT:   state_nxt = S_RESP;
      S_CLEAR:    state_nxt = S_RESP;
      S_RESP: begin
        if (resp_go) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mod_start  = (state_r == S_IDLE) && accept && (in_ch.data.opcode != OP_CLEAR);
    we         = 1'b0;
    waddr      = {bkt_r, idx_s};
    wkey       = key_r;
    wval       = val_r;
    raddr      = {bkt_r, idx_s};
    idx_nxt    = idx_r;
    fill_we    = 1'b0;
    fill_wdata = fill_cur;
    case (state_r)
      S_FILL: idx_nxt = '0;
      S_SCAN_CMP: begin
        if (rkey != key_r) begin
          idx_nxt = idx_r + FW'(1);
        end
      end
      S_SHIFT_RD: begin
        raddr = {bkt_r, SW'(idx_r + FW'(1))};
        if (idx_r + FW'(1) >= fill_cur) begin
          fill_we    = 1'b1;
          fill_wdata = fill_cur - FW'(1);
        end
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        wkey    = rkey;
        wval    = rval;
        idx_nxt = idx_r + FW'(1);
      end
      S_INSERT: begin
        we         = (fill_cur < FW'(SLOTS_PER_BUCKET));
        waddr      = {bkt_r, SW'(fill_cur)};
        fill_we    = (fill_cur < FW'(SLOTS_PER_BUCKET));
        fill_wdata = fill_cur + FW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[bkt_r] <= fill_wdata;
    end
    if (mod_done) begin
      fill_rd_r <= fill_mem[rem_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      bkt_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= resp_go || (ov_r && !out_ch.ready);
      case (state_r)
        S_CLEAR: begin
          bkt_vld_r <= '0;
          wres_r    <= '{status: ST_DONE, found_value: '0};
        end
        S_FILL: begin
          wres_r <= '{status: ST_NOTFOUND, found_value: '0};
        end
        S_INSERT: begin
          if (fill_cur < FW'(SLOTS_PER_BUCKET)) begin
            bkt_vld_r[bkt_r] <= 1'b1;
            wres_r <= '{status: ST_DONE, found_value: '0};
          end else begin
            wres_r <= '{status: ST_FULL, found_value: '0};
          end
        end
        S_SCAN_CMP: begin
          if (rkey == key_r) begin
            wres_r <= '{status: ST_DONE,
                        found_value: (op_r == OP_GET) ? rval : 32'd0};
          end
        end
        default: ;
      endcase
    end
    if (accept) begin
      op_r  <= in_ch.data.opcode;
      key_r <= in_ch.data.key;
      val_r <= in_ch.data.value;
    end
    if (mod_done) begin
      bkt_r      <= rem_b;
      bkt_live_r <= bkt_vld_r[rem_b];
    end
    if (resp_go) begin
      res_r <= wres_r;
    end
    idx_r <= idx_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;
endmodule
`default_nettype wire

// ===== design/chte_mod.sv =====
// Restoring bit-serial modulo unit: 64-bit dividend by a narrow divisor.
// Depends on chte_pkg.
`default_nettype none
module chte_mod
  import chte_pkg::*;
#(
  parameter int DW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      remainder
);
  logic [63:0]   dvd_r, dvd_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, dvd_r[63]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == 7'd1);
  assign remainder = rem_nxt;
endmodule
`default_nettype wire

// ===== design/chte_store.sv =====
// Slot memories for keys and values: one write and one registered read port.
// Depends on chte_pkg.
`default_nettype none
module chte_store
  import chte_pkg::*;
#(
  parameter int AW = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wkey,
  input  wire logic [31:0]   wval,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rkey,
  output logic [31:0]        rval
);
  logic [63:0] mem [2**AW];
  logic [63:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkey, wval};
    end
    rd_r <= mem[raddr];
  end

  assign rkey = rd_r[63:32];
  assign rval = rd_r[31:0];
endmodule
`default_nettype wire

// ===== design/chte_checker.sv =====
// Port-level checker for the chained hash table engine, bound to the top.
// Depends on chte_pkg for the status codes.
`default_nettype none
module chte_checker
  import chte_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_found_value
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
                                && $stable(out_found_value))
    else $error("result changed under stall");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_NOTFOUND
                   || out_status == ST_FULL))
    else $error("illegal status code");
  a_fv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_found_value == 32'd0)
    else $error("value on failed result");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("two items taken back to back");
endmodule

bind chained_hash_table_engine chte_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_found_value(out_found_value)
);
`default_nettype wire

// ===== bench/tb_chained_hash_table_engine.sv =====
// Self-checking testbench for chained_hash_table_engine: a scoreboard class
// predicts every result, and plain tasks drive the channels.
// Depends on chte_pkg, chte_if and the engine itself.
`default_nettype none
module tb_chained_hash_table_engine;
  import chte_pkg::*;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] key;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] found;
  } answer_t;

  // Table predictor with its own copy of the slots, fill counts and the
  // bucket count, plus the queue of answers still owed by the engine.
  class table_scoreboard;
    logic [31:0] keys [MaxBucketsDef][SlotsPerBucketDef];
    logic [31:0] vals [MaxBucketsDef][SlotsPerBucketDef];
    int          fill [MaxBucketsDef];
    int          buckets_used;
    answer_t     owed [$];
    int          errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      buckets_used = NumBucketsRst;
      errors = 0;
    endfunction

    function void set_buckets(logic [6:0] n);
      if (n == 0) buckets_used = 1;
      else if (n > MaxBucketsDef) buckets_used = MaxBucketsDef;
      else buckets_used = n;
    endfunction

    // Works out the answer to one accepted request and updates the table.
    function void note_request(request_t r);
      logic [63:0] wide;
      int          b;
      int          pos;
      answer_t     a;
      a.st = ST_DONE;
      a.found = '0;
      wide = {{32{r.key[31]}}, r.key};
      b = int'(wide % 64'(buckets_used));
      if (r.op == OP_CLEAR) begin
        foreach (fill[i]) fill[i] = 0;
      end else if (r.op == OP_INSERT) begin
        if (fill[b] >= SlotsPerBucketDef) begin
          a.st = ST_FULL;
        end else begin
          keys[b][fill[b]] = r.key;
          vals[b][fill[b]] = r.value;
          fill[b]++;
        end
      end else begin
        pos = -1;
        for (int i = 0; i < fill[b]; i++)
          if (pos < 0 && keys[b][i] == r.key) pos = i;
        if (pos < 0) begin
          a.st = ST_NOTFOUND;
        end else if (r.op == OP_GET) begin
          a.found = vals[b][pos];
        end else begin
          for (int i = pos; i + 1 < fill[b]; i++) begin
            keys[b][i] = keys[b][i+1];
            vals[b][i] = vals[b][i+1];
          end
          fill[b]--;
        end
      end
      owed = {owed, a};
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (owed.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.st !== want.st) begin
        $error("status: expected %0d, actual %0d", want.st, got.st);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found_value: expected %h, actual %h", want.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  chte_if #(.payload_t(request_t))   req_ch ();
  chte_if #(.payload_t(answer_t))    ans_ch ();
  chte_if #(.payload_t(logic [6:0])) cfg_ch ();

  logic [1:0]  out_status_w;
  logic [31:0] out_found_w;
  logic        out_valid_w;

  assign ans_ch.valid = out_valid_w;
  assign ans_ch.data  = {status_t'(out_status_w), out_found_w};

  chained_hash_table_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req_ch.valid),
    .in_ready        (req_ch.ready),
    .in_opcode       (req_ch.data.op),
    .in_key          (req_ch.data.key),
    .in_value        (req_ch.data.value),
    .out_valid       (out_valid_w),
    .out_ready       (ans_ch.ready),
    .out_status      (out_status_w),
    .out_found_value (out_found_w),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_num_buckets (cfg_ch.data)
  );

  table_scoreboard sb = new();

  // Handshake flags: raised by the monitor at the rising edge, consumed by
  // the drivers at the following falling edge.
  bit req_taken;
  bit cfg_taken;

  // Idling controls in percent, and a counted hold-off of the receiver.
  int idle_pct;
  int stall_pct;
  int hold_left;

  logic [31:0] key_pool [16];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Monitor: every transfer is sampled at the rising edge, before the
  // engine's own registers update.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.data);
        req_taken = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_buckets(cfg_ch.data);
        cfg_taken = 1'b1;
      end
      if (ans_ch.valid && ans_ch.ready)
        sb.check_result(ans_ch.data);
    end
  end

  // Receiver: either a long counted hold-off, or random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      ans_ch.ready <= 1'b0;
    end else begin
      ans_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one request, with a random number of idle cycles ahead of it.
  // Valid is left high afterwards so that back-to-back items do not drop it.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(negedge clk); while (!req_taken);
    req_taken = 1'b0;
  endtask

  task automatic issue(opcode_t op, logic [31:0] key, logic [31:0] value);
    request_t r;
    r.op = op;
    r.key = key;
    r.value = value;
    send_request(r);
  endtask

  // Lets the engine drain completely, with some slack so that the next
  // configuration write lands well after the engine has gone idle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_buckets(logic [6:0] n);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= n;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic refill_pool();
    foreach (key_pool[i]) begin
      case ($urandom_range(3))
        0: key_pool[i] = $urandom;
        1: key_pool[i] = $urandom_range(0, 300);
        2: key_pool[i] = -$urandom_range(1, 300);
        default: key_pool[i] = {$urandom_range(1) ? 26'h3ffffff : 26'h0,
                                6'($urandom_range(63))};
      endcase
    end
  endtask

  // Mostly keys from a small pool, so that gets and removes hit and
  // buckets fill up; now and then a fresh key or a clear.
  task automatic random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 45) r.op = OP_INSERT;
    else if (pick < 72) r.op = OP_GET;
    else if (pick < 97) r.op = OP_REMOVE;
    else r.op = OP_CLEAR;
    r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(15)] : $urandom;
    r.value = $urandom;
    send_request(r);
  endtask

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [6:0] settings [8];
    int         idle_modes [4];
    int         stall_modes [4];
    settings = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd3, 7'd64, 7'd33};
    idle_modes = '{0, 68, 0, 11};
    stall_modes = '{0, 0, 68, 11};

    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    ans_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with 64 buckets: extreme keys and values, duplicates,
    // missing keys, a full bucket and a clear.
    write_buckets(7'd64);
    issue(OP_INSERT, 32'h0000_0000, 32'h7fff_ffff);
    issue(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    issue(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    issue(OP_GET,    32'hffff_ffff, 32'h0);
    issue(OP_GET,    32'h0000_0000, 32'hffff_ffff);
    issue(OP_GET,    32'h0000_0040, 32'h0);
    issue(OP_REMOVE, 32'h0000_0000, 32'h0);
    issue(OP_GET,    32'h8000_0000, 32'h0);
    issue(OP_REMOVE, 32'h7fff_ffff, 32'h0);
    issue(OP_INSERT, 32'd5, 32'haaaa_5555);
    issue(OP_INSERT, 32'd5, 32'h5555_aaaa);
    issue(OP_GET,    32'd5, 32'h0);
    issue(OP_REMOVE, 32'd5, 32'h0);
    issue(OP_GET,    32'd5, 32'h0);
    // Nine inserts into bucket one: the last finds the bucket full.
    for (int i = 0; i < 9; i++)
      issue(OP_INSERT, 32'(1 + 64 * i), $urandom);
    issue(OP_REMOVE, 32'd65, 32'h0);
    issue(OP_CLEAR,  32'h0, 32'h0);
    issue(OP_GET,    32'd1, 32'h0);
    drain();

    // Random part: each phase picks a bucket count and an idling mode.
    // Entries are kept across phases, so they live on under a new modulo.
    for (int ph = 0; ph < 8; ph++) begin
      write_buckets(settings[ph]);
      refill_pool();
      idle_pct = idle_modes[ph % 4];
      stall_pct = stall_modes[ph % 4];
      // In one phase the receiver holds off for a long stretch while the
      // sender keeps offering, so the engine backs up to its input.
      if (ph == 1) hold_left = 400;
      for (int n = 0; n < 140; n++)
        random_request();
      drain();
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
